// ===== rtl/json_string_object_stream_parser_assert.svh =====
// Assertion macros for the JSON object parser
`ifndef JSON_STRING_OBJECT_STREAM_PARSER_ASSERT_SVH
`define JSON_STRING_OBJECT_STREAM_PARSER_ASSERT_SVH
`ifndef SYNTH
`define JSOP_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define JSOP_ASSERT_NR(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define JSOP_ASSERT(label, clk, rst_n, prop, msg)
`define JSOP_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

// ===== rtl/jsop_pkg.sv =====
`timescale 1ns / 1ps
package jsop_pkg;

    typedef enum logic [4:0] {
        S_START, S_OBJ_FIRST, S_KEY_NEXT, S_COLON, S_VALUE, S_ARR_FIRST, S_ARR_NEXT,
        S_AFTER_ITEM, S_AFTER_VAL, S_TAIL, S_STR, S_ESC, S_HEX, S_SURR_BS, S_SURR_U,
        S_LOW_HEX, S_ERROR
    } t_state;

    localparam logic [2:0] K_BYTE      = 3'd0;
    localparam logic [2:0] K_STR_END   = 3'd1;
    localparam logic [2:0] K_ARR_BEGIN = 3'd2;
    localparam logic [2:0] K_ARR_END   = 3'd3;
    localparam logic [2:0] K_OK        = 3'd4;
    localparam logic [2:0] K_ERROR     = 3'd5;

    localparam logic [1:0] R_KEY   = 2'd0;
    localparam logic [1:0] R_VALUE = 2'd1;
    localparam logic [1:0] R_ITEM  = 2'd2;

    localparam logic [4:0] E_OPEN      = 5'd0;
    localparam logic [4:0] E_STR_EXP   = 5'd1;
    localparam logic [4:0] E_COLON     = 5'd2;
    localparam logic [4:0] E_VALUE     = 5'd3;
    localparam logic [4:0] E_ITEM      = 5'd4;
    localparam logic [4:0] E_COMMA_BRK = 5'd5;
    localparam logic [4:0] E_COMMA_BRC = 5'd6;
    localparam logic [4:0] E_UNTERM    = 5'd7;
    localparam logic [4:0] E_CTRL      = 5'd8;
    localparam logic [4:0] E_BS_END    = 5'd9;
    localparam logic [4:0] E_ESC       = 5'd10;
    localparam logic [4:0] E_HEX_SHORT = 5'd11;
    localparam logic [4:0] E_NOT_HEX   = 5'd12;
    localparam logic [4:0] E_PAIR      = 5'd13;
    localparam logic [4:0] E_BAD_LOW   = 5'd14;
    localparam logic [4:0] E_LONE_LOW  = 5'd15;
    localparam logic [4:0] E_TRAIL     = 5'd16;

    // Instruction passed from the front to the back part
    typedef enum logic [2:0] {
        OP_NONE, OP_BYTE, OP_CP, OP_PAIR, OP_MARK, OP_ERR
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [2:0]  kind;
        logic [1:0]  role;
        logic [15:0] val;       // byte, code point, or low surrogate
        logic [9:0]  high;      // high surrogate bits for a pair
        logic [4:0]  code;
        logic [15:0] pos;
    } t_cmd;

    typedef struct packed {
        logic [2:0]  kind;
        logic [1:0]  role;
        logic [7:0]  out_byte;
        logic [4:0]  error_code;
        logic [15:0] error_position;
        logic        last;
    } t_res;

    function automatic logic [4:0] hex_val(input logic [7:0] b);
        logic [4:0] v;
        v = 5'd16;
        if (b >= "0" && b <= "9") v = 5'(b - 8'h30);
        else if (b >= "a" && b <= "f") v = 5'(b - 8'h57);
        else if (b >= "A" && b <= "F") v = 5'(b - 8'h37);
        return v;
    endfunction

endpackage

// ===== rtl/jsop_front.sv =====
`timescale 1ns / 1ps
`include "json_string_object_stream_parser_assert.svh"
// Parser front: consumes one byte per cycle and issues at most one command per item
module jsop_front #(
    parameter int POS_CAP = 65535
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [7:0]        i_data_byte,
    input  logic              i_end_of_text,
    output logic              o_cmd_valid,
    output jsop_pkg::t_cmd    o_cmd
);

    jsop_pkg::t_state r_state, n_state;
    logic [1:0]  r_role, n_role;
    logic [15:0] r_acc, n_acc;
    logic [1:0]  r_cnt, n_cnt;
    logic [9:0]  r_high, n_high;
    logic [15:0] r_pos, n_pos;
    logic [15:0] r_spos, n_spos;
    logic        r_err, n_err;
    jsop_pkg::t_cmd c;

    logic [15:0] p1, start, cp;
    logic [4:0]  hv;
    logic        sp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= jsop_pkg::S_START;
            r_role  <= '0;
            r_acc   <= '0;
            r_cnt   <= '0;
            r_high  <= '0;
            r_pos   <= '0;
            r_spos  <= '0;
            r_err   <= 1'b0;
        end else if (i_valid) begin
            r_state <= n_state;
            r_role  <= n_role;
            r_acc   <= n_acc;
            r_cnt   <= n_cnt;
            r_high  <= n_high;
            r_pos   <= n_pos;
            r_spos  <= n_spos;
            r_err   <= n_err;
        end
    end

    assign o_cmd_valid = i_valid && (c.op != jsop_pkg::OP_NONE);
    assign o_cmd = c;

    // Next state and command
    always_comb begin
        n_state = r_state;
        n_role  = r_role;
        n_acc   = r_acc;
        n_cnt   = r_cnt;
        n_high  = r_high;
        n_spos  = r_spos;
        n_err   = r_err;
        p1      = (r_pos >= 16'(POS_CAP)) ? 16'(POS_CAP) : r_pos + 16'd1;
        n_pos   = p1;
        start   = r_pos - 16'(r_cnt);
        hv      = jsop_pkg::hex_val(i_data_byte);
        cp      = {r_acc[11:0], hv[3:0]};
        sp      = i_data_byte == " " || i_data_byte == 8'h09 ||
                  i_data_byte == 8'h0A || i_data_byte == 8'h0D;
        c       = '0;
        c.op    = jsop_pkg::OP_NONE;

        if (i_end_of_text) begin
            c.op = jsop_pkg::OP_ERR;
            c.kind = jsop_pkg::K_ERROR;
            c.pos = r_pos;
            case (r_state)
                jsop_pkg::S_START: c.code = jsop_pkg::E_OPEN;
                jsop_pkg::S_OBJ_FIRST, jsop_pkg::S_KEY_NEXT: c.code = jsop_pkg::E_STR_EXP;
                jsop_pkg::S_COLON: c.code = jsop_pkg::E_COLON;
                jsop_pkg::S_VALUE: c.code = jsop_pkg::E_VALUE;
                jsop_pkg::S_ARR_FIRST, jsop_pkg::S_ARR_NEXT: c.code = jsop_pkg::E_ITEM;
                jsop_pkg::S_AFTER_ITEM: c.code = jsop_pkg::E_COMMA_BRK;
                jsop_pkg::S_AFTER_VAL: c.code = jsop_pkg::E_COMMA_BRC;
                jsop_pkg::S_TAIL: begin
                    c.op = jsop_pkg::OP_MARK;
                    c.kind = jsop_pkg::K_OK;
                    c.pos = '0;
                end
                jsop_pkg::S_STR: c.code = jsop_pkg::E_UNTERM;
                jsop_pkg::S_ESC: c.code = jsop_pkg::E_BS_END;
                jsop_pkg::S_HEX, jsop_pkg::S_LOW_HEX: begin
                    c.code = jsop_pkg::E_HEX_SHORT;
                    c.pos = start;
                end
                jsop_pkg::S_SURR_BS, jsop_pkg::S_SURR_U: begin
                    c.code = jsop_pkg::E_PAIR;
                    c.pos = r_spos;
                end
                default: c.op = jsop_pkg::OP_NONE;
            endcase
            if (r_state >= jsop_pkg::S_STR && r_role == jsop_pkg::R_ITEM)
                c.code = jsop_pkg::E_ITEM;
            if (r_err) c.op = jsop_pkg::OP_NONE;
            n_state = jsop_pkg::S_START;
            n_role = '0; n_acc = '0; n_cnt = '0; n_high = '0;
            n_pos = '0; n_spos = '0; n_err = 1'b0;
        end else if (!r_err && !(r_state < jsop_pkg::S_STR && sp)) begin
            c.kind = jsop_pkg::K_ERROR;
            c.pos = r_pos;
            case (r_state)
                jsop_pkg::S_START:
                    if (i_data_byte == "{") n_state = jsop_pkg::S_OBJ_FIRST;
                    else begin c.op = jsop_pkg::OP_ERR; c.code = jsop_pkg::E_OPEN; end
                jsop_pkg::S_OBJ_FIRST:
                    if (i_data_byte == "}") n_state = jsop_pkg::S_TAIL;
                    else if (i_data_byte == "\"") begin
                        n_role = jsop_pkg::R_KEY; n_state = jsop_pkg::S_STR;
                    end else begin c.op = jsop_pkg::OP_ERR; c.code = jsop_pkg::E_STR_EXP; end
                jsop_pkg::S_KEY_NEXT:
                    if (i_data_byte == "\"") begin
                        n_role = jsop_pkg::R_KEY; n_state = jsop_pkg::S_STR;
                    end else begin c.op = jsop_pkg::OP_ERR; c.code = jsop_pkg::E_STR_EXP; end
                jsop_pkg::S_COLON:
                    if (i_data_byte == ":") n_state = jsop_pkg::S_VALUE;
                    else begin c.op = jsop_pkg::OP_ERR; c.code = jsop_pkg::E_COLON; end
                jsop_pkg::S_VALUE:
                    if (i_data_byte == "\"") begin
                        n_role = jsop_pkg::R_VALUE; n_state = jsop_pkg::S_STR;
                    end else if (i_data_byte == "[") begin
                        c.op = jsop_pkg::OP_MARK; c.kind = jsop_pkg::K_ARR_BEGIN;
                        c.pos = '0; n_state = jsop_pkg::S_ARR_FIRST;
                    end else begin c.op = jsop_pkg::OP_ERR; c.code = jsop_pkg::E_VALUE; end
                jsop_pkg::S_ARR_FIRST, jsop_pkg::S_ARR_NEXT:
                    if (i_data_byte == "]" && r_state == jsop_pkg::S_ARR_FIRST) begin
                        c.op = jsop_pkg::OP_MARK; c.kind = jsop_pkg::K_ARR_END;
                        c.pos = '0; n_state = jsop_pkg::S_AFTER_VAL;
                    end else if (i_data_byte == "\"") begin
                        n_role = jsop_pkg::R_ITEM; n_state = jsop_pkg::S_STR;
                    end else begin c.op = jsop_pkg::OP_ERR; c.code = jsop_pkg::E_ITEM; end
                jsop_pkg::S_AFTER_ITEM:
                    if (i_data_byte == ",") n_state = jsop_pkg::S_ARR_NEXT;
                    else if (i_data_byte == "]") begin
                        c.op = jsop_pkg::OP_MARK; c.kind = jsop_pkg::K_ARR_END;
                        c.pos = '0; n_state = jsop_pkg::S_AFTER_VAL;
                    end else begin c.op = jsop_pkg::OP_ERR; c.code = jsop_pkg::E_COMMA_BRK; end
                jsop_pkg::S_AFTER_VAL:
                    if (i_data_byte == ",") n_state = jsop_pkg::S_KEY_NEXT;
                    else if (i_data_byte == "}") n_state = jsop_pkg::S_TAIL;
                    else begin c.op = jsop_pkg::OP_ERR; c.code = jsop_pkg::E_COMMA_BRC; end
                jsop_pkg::S_TAIL: begin
                    c.op = jsop_pkg::OP_ERR; c.code = jsop_pkg::E_TRAIL;
                end
                jsop_pkg::S_STR: begin
                    if (i_data_byte == "\"") begin
                        c.op = jsop_pkg::OP_MARK; c.kind = jsop_pkg::K_STR_END;
                        c.role = r_role; c.pos = '0;
                        n_state = (r_role == jsop_pkg::R_KEY) ? jsop_pkg::S_COLON :
                                  (r_role == jsop_pkg::R_VALUE) ? jsop_pkg::S_AFTER_VAL :
                                  jsop_pkg::S_AFTER_ITEM;
                    end else if (i_data_byte == "\\") n_state = jsop_pkg::S_ESC;
                    else if (i_data_byte < 8'h20) begin
                        c.op = jsop_pkg::OP_ERR; c.code = jsop_pkg::E_CTRL; c.pos = p1;
                    end else begin
                        c.op = jsop_pkg::OP_BYTE; c.val = {8'h00, i_data_byte};
                    end
                end
                jsop_pkg::S_ESC: begin
                    n_state = jsop_pkg::S_STR;
                    c.op = jsop_pkg::OP_BYTE;
                    case (i_data_byte)
                        "\"", "\\", "/": c.val = {8'h00, i_data_byte};
                        "b": c.val = 16'h0008;
                        "f": c.val = 16'h000C;
                        "n": c.val = 16'h000A;
                        "r": c.val = 16'h000D;
                        "t": c.val = 16'h0009;
                        "u": begin
                            c.op = jsop_pkg::OP_NONE;
                            n_acc = '0; n_cnt = '0; n_state = jsop_pkg::S_HEX;
                        end
                        default: begin
                            c.op = jsop_pkg::OP_ERR; c.code = jsop_pkg::E_ESC; c.pos = p1;
                        end
                    endcase
                end
                jsop_pkg::S_HEX, jsop_pkg::S_LOW_HEX: begin
                    if (hv[4]) begin
                        c.op = jsop_pkg::OP_ERR; c.code = jsop_pkg::E_NOT_HEX; c.pos = p1;
                    end else if (r_cnt != 2'd3) begin
                        n_acc = cp; n_cnt = r_cnt + 2'd1;
                    end else begin
                        n_acc = cp; n_cnt = '0;
                        if (r_state == jsop_pkg::S_LOW_HEX) begin
                            if (cp < 16'hDC00 || cp > 16'hDFFF) begin
                                c.op = jsop_pkg::OP_ERR; c.code = jsop_pkg::E_BAD_LOW;
                                c.pos = p1;
                            end else begin
                                c.op = jsop_pkg::OP_PAIR; c.val = cp; c.high = r_high;
                                n_state = jsop_pkg::S_STR;
                            end
                        end else if (cp >= 16'hD800 && cp <= 16'hDBFF) begin
                            n_high = cp[9:0]; n_spos = p1; n_state = jsop_pkg::S_SURR_BS;
                        end else if (cp >= 16'hDC00 && cp <= 16'hDFFF) begin
                            c.op = jsop_pkg::OP_ERR; c.code = jsop_pkg::E_LONE_LOW;
                            c.pos = p1;
                        end else begin
                            c.op = jsop_pkg::OP_CP; c.val = cp; n_state = jsop_pkg::S_STR;
                        end
                    end
                end
                jsop_pkg::S_SURR_BS:
                    if (i_data_byte == "\\") n_state = jsop_pkg::S_SURR_U;
                    else begin c.op = jsop_pkg::OP_ERR; c.code = jsop_pkg::E_PAIR; c.pos = r_spos; end
                jsop_pkg::S_SURR_U:
                    if (i_data_byte == "u") begin
                        n_acc = '0; n_cnt = '0; n_state = jsop_pkg::S_LOW_HEX;
                    end else begin
                        c.op = jsop_pkg::OP_ERR; c.code = jsop_pkg::E_PAIR; c.pos = r_spos;
                    end
                default: ;
            endcase
            if (c.op == jsop_pkg::OP_BYTE || c.op == jsop_pkg::OP_CP ||
                c.op == jsop_pkg::OP_PAIR) c.role = r_role;
            if (c.op == jsop_pkg::OP_ERR) begin
                if (r_state >= jsop_pkg::S_STR && r_role == jsop_pkg::R_ITEM)
                    c.code = jsop_pkg::E_ITEM;
                n_state = jsop_pkg::S_ERROR;
                n_err = 1'b1;
            end
        end
    end

    `JSOP_ASSERT(a_err_sticky, i_clk, i_rst_n,
        (r_err && !(i_valid && i_end_of_text)) |=> r_err, "error flag dropped")
    `JSOP_ASSERT(a_err_state, i_clk, i_rst_n,
        r_err |-> (r_state == jsop_pkg::S_ERROR), "error flag without error state")
    `JSOP_ASSERT(a_no_cmd_err, i_clk, i_rst_n,
        (r_err && i_valid && !i_end_of_text) |-> !o_cmd_valid, "command after error")

endmodule

// ===== rtl/jsop_queue.sv =====
`timescale 1ns / 1ps
`include "json_string_object_stream_parser_assert.svh"
// Small command queue between front and back
module jsop_queue #(
    parameter int DEPTH = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  jsop_pkg::t_cmd  i_cmd,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_empty,
    output jsop_pkg::t_cmd  o_cmd
);
    localparam int AW = $clog2(DEPTH);

    jsop_pkg::t_cmd r_mem [DEPTH];
    logic [AW-1:0] r_wr, r_rd;
    logic [AW:0]   r_cnt;
    logic do_push, do_pop;

    assign o_full  = r_cnt == (AW+1)'(DEPTH);
    assign o_empty = r_cnt == '0;
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_cmd   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr] <= i_cmd;
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0; r_rd <= '0; r_cnt <= '0;
        end else begin
            if (do_push) r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
            if (do_pop)  r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
            r_cnt <= r_cnt + (AW+1)'(do_push) - (AW+1)'(do_pop);
        end
    end

    `JSOP_ASSERT(a_q_bound, i_clk, i_rst_n, r_cnt <= (AW+1)'(DEPTH), "queue overflow")
    `JSOP_ASSERT(a_q_ptr, i_clk, i_rst_n,
        (r_cnt == '0 || r_cnt == (AW+1)'(DEPTH)) |-> (r_wr == r_rd), "pointer mismatch")
    `JSOP_ASSERT(a_q_count, i_clk, i_rst_n,
        (do_push && !do_pop) |=> (r_cnt == $past(r_cnt) + (AW+1)'(1)), "count slip")

endmodule

// ===== rtl/jsop_back.sv =====
`timescale 1ns / 1ps
`include "json_string_object_stream_parser_assert.svh"
// Back part: expands one command into up to four results, one per cycle while the output register is free
module jsop_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cmd_valid,
    input  jsop_pkg::t_cmd  i_cmd,
    output logic            o_cmd_take,
    output logic            o_empty,
    input  logic            i_pop,
    output jsop_pkg::t_res  o_res
);
    logic [20:0] cp;
    logic [2:0]  nbytes;
    logic [7:0]  b [4];
    logic        r_busy;
    logic [1:0]  r_idx;
    logic [2:0]  r_n;
    logic [7:0]  r_b [4];
    logic [1:0]  r_role;
    logic        r_valid;
    jsop_pkg::t_res r_res;
    logic        slot_free, emit_now, finish;
    jsop_pkg::t_res nxt;

    // UTF-8 encoding of the command's code point
    always_comb begin
        cp = (i_cmd.op == jsop_pkg::OP_PAIR) ?
             21'h10000 + {1'b0, i_cmd.high, 10'h000} + 21'(i_cmd.val[9:0]) :
             21'(i_cmd.val);
        b[0] = cp[7:0]; b[1] = '0; b[2] = '0; b[3] = '0;
        if (i_cmd.op == jsop_pkg::OP_BYTE || cp < 21'h80) begin
            nbytes = 3'd1;
        end else if (cp < 21'h800) begin
            nbytes = 3'd2;
            b[0] = 8'hC0 | 8'(cp[10:6]); b[1] = 8'h80 | 8'(cp[5:0]);
        end else if (cp < 21'h10000) begin
            nbytes = 3'd3;
            b[0] = 8'hE0 | 8'(cp[15:12]); b[1] = 8'h80 | 8'(cp[11:6]);
            b[2] = 8'h80 | 8'(cp[5:0]);
        end else begin
            nbytes = 3'd4;
            b[0] = 8'hF0 | 8'(cp[20:18]); b[1] = 8'h80 | 8'(cp[17:12]);
            b[2] = 8'h80 | 8'(cp[11:6]); b[3] = 8'h80 | 8'(cp[5:0]);
        end
    end

    assign slot_free  = !r_valid || i_pop;
    assign o_cmd_take = slot_free && !r_busy && i_cmd_valid;
    assign emit_now   = slot_free && (r_busy || i_cmd_valid);
    assign finish     = r_busy && (3'(r_idx) + 3'd1 == r_n);
    assign o_empty    = !r_valid;
    assign o_res      = r_res;

    // Next result word
    always_comb begin
        nxt = '0;
        if (r_busy) begin
            nxt.kind = jsop_pkg::K_BYTE;
            nxt.role = r_role;
            nxt.out_byte = r_b[r_idx];
            nxt.last = finish;
        end else if (i_cmd.op == jsop_pkg::OP_ERR || i_cmd.op == jsop_pkg::OP_MARK) begin
            nxt.kind = i_cmd.kind;
            nxt.role = (i_cmd.kind == jsop_pkg::K_STR_END) ? i_cmd.role : '0;
            nxt.error_code = i_cmd.code;
            nxt.error_position = i_cmd.pos;
            nxt.last = 1'b1;
        end else begin
            nxt.kind = jsop_pkg::K_BYTE;
            nxt.role = i_cmd.role;
            nxt.out_byte = b[0];
            nxt.last = nbytes == 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_now) r_res <= nxt;
        if (o_cmd_take) begin
            r_b[0] <= b[0]; r_b[1] <= b[1]; r_b[2] <= b[2]; r_b[3] <= b[3];
            r_n <= nbytes; r_role <= i_cmd.role;
        end
    end

    // Sequencer for multi-byte expansion
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0; r_busy <= 1'b0; r_idx <= '0;
        end else begin
            if (emit_now) r_valid <= 1'b1;
            else if (i_pop) r_valid <= 1'b0;
            if (emit_now && r_busy) begin
                if (finish) r_busy <= 1'b0;
                r_idx <= r_idx + 2'd1;
            end else if (o_cmd_take && nxt.kind == jsop_pkg::K_BYTE && !nxt.last) begin
                r_busy <= 1'b1;
                r_idx <= 2'd1;
            end
        end
    end

    `JSOP_ASSERT(a_b_kind, i_clk, i_rst_n, r_valid |-> (r_res.kind <= jsop_pkg::K_ERROR),
        "bad result kind")
    `JSOP_ASSERT(a_b_busy, i_clk, i_rst_n, r_busy |-> !o_cmd_take, "take while busy")
    `JSOP_ASSERT(a_b_last, i_clk, i_rst_n,
        (r_busy && emit_now && !finish) |=> (r_valid && !r_res.last), "early last")

endmodule

// ===== rtl/json_string_object_stream_parser.sv =====
`timescale 1ns / 1ps
// JSON string-object stream parser.
// Input channel: push/full with i_data_byte and i_end_of_text; one text byte or
// an end-of-text mark per item. Result channel: empty/pop; each result carries
// kind, role, out_byte, error_code, error_position and last.
// The front parser takes one item per cycle while full is low and turns it into
// at most one command, which waits in a four-entry queue. The back part writes
// one result per cycle into the output register while that register is free;
// a unicode escape expands to up to four UTF-8 bytes, and the back part takes
// no new command until the last of them is written. An accepted item's command
// is written into the queue, then its first result into the output register.
// Throughput: one item per cycle while the queue has room; full rises only
// when the queue fills, which takes a stalled receiver or long escape runs.
// Reset clears the parser and the queue and empties the output register; the
// block then waits for an opening brace. When pop stays low, results hold and
// the queue fills, and then full stops further input.
module json_string_object_stream_parser #(
    parameter int MAX_TEXT_BYTES = 65536
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_data_byte,
    input  logic        i_end_of_text,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  o_kind,
    output logic [1:0]  o_role,
    output logic [7:0]  o_out_byte,
    output logic [4:0]  o_error_code,
    output logic [15:0] o_error_position,
    output logic        o_last
);
    localparam int POS_CAP = (MAX_TEXT_BYTES - 1 < 65535) ? MAX_TEXT_BYTES - 1 : 65535;

    logic           f_valid, q_full, q_empty, take;
    jsop_pkg::t_cmd f_cmd, q_cmd;
    jsop_pkg::t_res res;

    assign full = q_full;

    jsop_front #(.POS_CAP(POS_CAP)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(push && !q_full),
        .i_data_byte(i_data_byte), .i_end_of_text(i_end_of_text),
        .o_cmd_valid(f_valid), .o_cmd(f_cmd)
    );

    jsop_queue #(.DEPTH(4)) u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(f_valid), .i_cmd(f_cmd),
        .o_full(q_full), .i_pop(take), .o_empty(q_empty), .o_cmd(q_cmd)
    );

    jsop_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd_valid(!q_empty), .i_cmd(q_cmd),
        .o_cmd_take(take), .o_empty(empty), .i_pop(pop), .o_res(res)
    );

    assign o_kind           = res.kind;
    assign o_role           = res.role;
    assign o_out_byte       = res.out_byte;
    assign o_error_code     = res.error_code;
    assign o_error_position = res.error_position;
    assign o_last           = res.last;

endmodule
